### hdl/bgcd_pkg.sv
// Shared widths, types and pipeline depths for the binary GCD pipeline.
`timescale 1ns / 1ps
`default_nettype none

package bgcd_pkg;

    // Operand and result width.
    localparam int DATA_WIDTH = 32;

    // Width of the common power-of-two count; also the number of
    // trailing-zero normalization stages (one per bit of the count).
    localparam int SHIFT_W = $clog2(DATA_WIDTH);
    localparam int NORM_STAGES = SHIFT_W;

    // Each reduction stage at least halves a*b while b is nonzero, and
    // a*b < 2^(2*DATA_WIDTH), so this many stages always drive b to zero.
    localparam int REDUCE_STAGES = 2 * DATA_WIDTH;

    typedef logic [DATA_WIDTH-1:0] data_t;
    typedef logic [DATA_WIDTH:0]   ext_t;
    typedef logic [SHIFT_W-1:0]    shift_t;

    // Working values carried down the pipeline with each item.
    typedef struct packed {
        data_t  a;
        data_t  b;
        shift_t common;
    } payload_t;

endpackage

`default_nettype wire

### hdl/bgcd_norm.sv
// Trailing-zero normalization stages: strip the common power of two, make a odd.
`timescale 1ns / 1ps
`default_nettype none

module bgcd_norm (
    input  wire                logic            clk,
    input  wire                logic            rst_n,
    input  wire                logic            adv,
    input  wire                logic            in_valid,
    input  wire                bgcd_pkg::data_t operand_a,
    input  wire                bgcd_pkg::data_t operand_b,
    output logic                                out_valid,
    output bgcd_pkg::payload_t                  out_data
);

    logic               [bgcd_pkg::NORM_STAGES-1:0] valid_reg;
    logic               [bgcd_pkg::NORM_STAGES-1:0] valid_in;
    bgcd_pkg::payload_t                             data_reg  [bgcd_pkg::NORM_STAGES];
    bgcd_pkg::payload_t                             data_in   [bgcd_pkg::NORM_STAGES];
    bgcd_pkg::payload_t                             data_next [bgcd_pkg::NORM_STAGES];

    genvar j;
    generate
        for (j = 0; j < bgcd_pkg::NORM_STAGES; j++)
        begin : g_stage
            // Stage j tests bit K of the count, highest bit first.
            localparam int K    = bgcd_pkg::NORM_STAGES - 1 - j;
            localparam int SPAN = 1 << K;

            bgcd_pkg::data_t x;

            // Feed the first stage from the ports, the rest from the stage before.
            if (j == 0)
            begin : g_first
                assign valid_in[j]       = in_valid;
                assign data_in[j].a      = operand_a;
                assign data_in[j].b      = operand_b;
                assign data_in[j].common = '0;
            end
            else
            begin : g_chain
                assign valid_in[j] = valid_reg[j-1];
                assign data_in[j]  = data_reg[j-1];
            end

            assign x = data_in[j].a | data_in[j].b;

            // Shift out SPAN zeros when the low SPAN bits of a|b are clear;
            // in the last stage put the odd operand in a.
            always_comb
            begin
                data_next[j] = data_in[j];
                if (x[SPAN-1:0] == '0)
                begin
                    data_next[j].a         = data_in[j].a >> SPAN;
                    data_next[j].b         = data_in[j].b >> SPAN;
                    data_next[j].common[K] = 1'b1;
                end
                if (K == 0 && !data_next[j].a[0])
                begin
                    {data_next[j].a, data_next[j].b} = {data_next[j].b, data_next[j].a};
                end
            end

            // Advance the valid bit.
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg[j] <= 1'b0;
                end
                else if (adv)
                begin
                    valid_reg[j] <= valid_in[j];
                end
            end

            // Advance the payload.
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    data_reg[j] <= data_next[j];
                end
            end
        end
    endgenerate

    assign out_valid = valid_reg[bgcd_pkg::NORM_STAGES-1];
    assign out_data  = data_reg[bgcd_pkg::NORM_STAGES-1];

endmodule

`default_nettype wire

### hdl/bgcd_step.sv
// One reduction stage: halve an even b, or subtract, halve, and swap if a > b.
`timescale 1ns / 1ps
`default_nettype none

module bgcd_step (
    input  wire                logic               clk,
    input  wire                logic               rst_n,
    input  wire                logic               adv,
    input  wire                logic               in_valid,
    input  wire                bgcd_pkg::payload_t in_data,
    output logic                                   out_valid,
    output bgcd_pkg::payload_t                     out_data
);

    logic               valid_reg;
    bgcd_pkg::payload_t data_reg;
    bgcd_pkg::payload_t data_next;
    bgcd_pkg::ext_t     diff_ba;
    bgcd_pkg::data_t    diff_ab;
    logic               a_gt_b;

    // Both differences in parallel; the borrow of b-a tells a > b.
    assign diff_ba = {1'b0, in_data.b} - {1'b0, in_data.a};
    assign diff_ab = in_data.a - in_data.b;
    assign a_gt_b  = diff_ba[bgcd_pkg::DATA_WIDTH];

    // a stays odd; the difference of two odd values is even, so halve it.
    always_comb
    begin
        data_next = in_data;
        if (in_data.b != '0)
        begin
            if (!in_data.b[0])
            begin
                data_next.b = in_data.b >> 1;
            end
            else if (a_gt_b)
            begin
                data_next.a = in_data.b;
                data_next.b = diff_ab >> 1;
            end
            else
            begin
                data_next.b = diff_ba[bgcd_pkg::DATA_WIDTH-1:0] >> 1;
            end
        end
    end

    // Advance the valid bit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= in_valid;
        end
    end

    // Advance the payload.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

### hdl/binary_gcd.sv
// Top level of the pipelined binary GCD: normalization, reduction chain, result register.
//
// Usage:
//   Request channel: operand_a, operand_b qualified by req_valid; the block
//   raises req_stall to hold off the sender. Response channel: divisor
//   qualified by rsp_valid; the receiver raises rsp_stall to hold it.
//   Either operand zero gives the other operand; both zero gives zero.
// Path: an accepted item passes the NORM_STAGES normalization registers, the
//   REDUCE_STAGES reduction registers and the result register before rsp_valid.
// Throughput: one item per cycle while req_stall is low. The reduction runs
//   as 2*DATA_WIDTH identical stages, enough for the worst-case operand pair,
//   so every item takes the same path regardless of its values.
// Stall: while a result waits in the output register, the pipeline keeps
//   moving and items keep entering until an item reaches the last stage;
//   only then does the whole pipeline freeze and req_stall rise.
// Reset: rst_n clears all valid bits; no item is in flight afterward.
`timescale 1ns / 1ps
`default_nettype none

module binary_gcd (
    input  wire  logic            clk,
    input  wire  logic            rst_n,
    input  wire  logic            req_valid,
    output logic                  req_stall,
    input  wire  bgcd_pkg::data_t operand_a,
    input  wire  bgcd_pkg::data_t operand_b,
    output logic                  rsp_valid,
    input  wire  logic            rsp_stall,
    output bgcd_pkg::data_t       divisor
);

    logic                                          adv;
    logic               [bgcd_pkg::REDUCE_STAGES:0] step_valid;
    bgcd_pkg::payload_t                            step_data [bgcd_pkg::REDUCE_STAGES+1];
    logic                                          last_valid;
    bgcd_pkg::payload_t                            last_data;
    logic                                          rsp_valid_reg;
    bgcd_pkg::data_t                               divisor_reg;
    bgcd_pkg::data_t                               divisor_next;

    // Freeze only when a finished item cannot move into a full, held output.
    assign adv       = !(last_valid && rsp_valid_reg && rsp_stall);
    assign req_stall = !adv;

    bgcd_norm u_norm (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (req_valid),
        .operand_a (operand_a),
        .operand_b (operand_b),
        .out_valid (step_valid[0]),
        .out_data  (step_data[0])
    );

    // Reduction chain.
    genvar s;
    generate
        for (s = 0; s < bgcd_pkg::REDUCE_STAGES; s++)
        begin : g_step
            bgcd_step u_step (
                .clk       (clk),
                .rst_n     (rst_n),
                .adv       (adv),
                .in_valid  (step_valid[s]),
                .in_data   (step_data[s]),
                .out_valid (step_valid[s+1]),
                .out_data  (step_data[s+1])
            );
        end
    endgenerate

    assign last_valid = step_valid[bgcd_pkg::REDUCE_STAGES];
    assign last_data  = step_data[bgcd_pkg::REDUCE_STAGES];

    // Restore the common power of two.
    assign divisor_next = last_data.a << last_data.common;

    // Load the output register whenever it is empty or being taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (!rsp_valid_reg || !rsp_stall)
        begin
            rsp_valid_reg <= last_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!rsp_valid_reg || !rsp_stall)
        begin
            divisor_reg <= divisor_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign divisor   = divisor_reg;

endmodule

`default_nettype wire

### hdl/bgcd_checker.sv
// Port-level checks for the binary GCD block and their binding to the top level.
`timescale 1ns / 1ps
`default_nettype none

module bgcd_checker (
    input wire logic            clk,
    input wire logic            rst_n,
    input wire logic            req_valid,
    input wire logic            req_stall,
    input wire bgcd_pkg::data_t operand_a,
    input wire bgcd_pkg::data_t operand_b,
    input wire logic            rsp_valid,
    input wire logic            rsp_stall,
    input wire bgcd_pkg::data_t divisor
);

    // The request side is held only when a result sits blocked at the output.
    a_stall_only_when_blocked: assert property (
        @(posedge clk) disable iff (!rst_n)
        req_stall |-> (rsp_valid && rsp_stall)
    ) else $error("req_stall raised while the output is free");

    // A held result keeps its value.
    a_rsp_hold: assert property (
        @(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(divisor))
    ) else $error("held result dropped or changed");

    // A held request keeps its operands.
    a_req_hold: assert property (
        @(posedge clk) disable iff (!rst_n)
        (req_valid && req_stall)
            |=> (req_valid && $stable(operand_a) && $stable(operand_b))
    ) else $error("stalled request dropped or changed");

    // Nothing comes out right after reset.
    a_empty_after_reset: assert property (
        @(posedge clk)
        $rose(rst_n) |-> !rsp_valid
    ) else $error("result presented with no item accepted");

    // Never hold off the sender while the output register is empty.
    a_no_stall_when_empty: assert property (
        @(posedge clk) disable iff (!rst_n)
        !rsp_valid |-> !req_stall
    ) else $error("req_stall raised with an empty output register");

endmodule

bind binary_gcd bgcd_checker u_bgcd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .operand_a (operand_a),
    .operand_b (operand_b),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .divisor   (divisor)
);

`default_nettype wire
